// File: rtl/core/spp_pkg.sv
// ----------------------------------------------------------------------------
// Starfield projector package
// Shared widths, register indexes, data types and placement arithmetic.
// ----------------------------------------------------------------------------
package spp_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 1024;
    localparam int unsigned SCREEN_W_DEF    = 800;
    localparam int unsigned SCREEN_H_DEF    = 600;

    localparam int unsigned POS_W    = 24;
    localparam int unsigned ID_W     = 10;
    localparam int unsigned RAND_W   = 16;
    localparam int unsigned SPREAD_W = 7;
    localparam int unsigned SPEED_W  = 20;
    localparam int unsigned CFG_W    = 20;
    localparam int unsigned PIX_W    = 10;
    localparam int unsigned ADDR_W   = 19;

    localparam logic [SPREAD_W-1:0] SPREAD_RST = 7'd20;
    localparam logic [SPEED_W-1:0]  SPEED_RST  = 20'd6554;

    typedef enum logic
    {
        REG_SPREAD = 1'b0,
        REG_SPEED  = 1'b1
    } cfg_reg_t;

    typedef enum logic
    {
        OP_PLACE   = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    typedef struct packed
    {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } star_t;

    typedef struct packed
    {
        logic [ID_W-1:0] id;
        logic            shown;
        logic [1:0]      resp;
    } meta_t;

    // (2r - 1) * spread in Q8.16, exact.
    function automatic logic signed [POS_W-1:0] lateral(
        input logic [RAND_W-1:0]   r,
        input logic [SPREAD_W-1:0] spread
    );
        logic signed [RAND_W+1:0]  f;
        logic signed [POS_W+1:0]   p;
        f = signed'({1'b0, r, 1'b0}) - 18'sd65536;
        p = (POS_W+2)'(f) * (POS_W+2)'(signed'({1'b0, spread}));
        return p[POS_W-1:0];
    endfunction

    // (r + one LSB) * spread in Q8.16, always non-negative.
    function automatic logic signed [POS_W-1:0] depth(
        input logic [RAND_W-1:0]   r,
        input logic [SPREAD_W-1:0] spread
    );
        logic [POS_W-1:0] p;
        p = POS_W'({1'b0, r} + 17'd1) * POS_W'(spread);
        return signed'(p);
    endfunction

    function automatic star_t place(
        input logic [RAND_W-1:0]   rx,
        input logic [RAND_W-1:0]   ry,
        input logic [RAND_W-1:0]   rz,
        input logic [SPREAD_W-1:0] spread
    );
        star_t s;
        s.x = lateral(rx, spread);
        s.y = lateral(ry, spread);
        s.z = depth(rz, spread);
        return s;
    endfunction

endpackage

// File: rtl/core/starfield_point_projector_core.sv
// ----------------------------------------------------------------------------
// Starfield point projector core
// Keeps a table of star positions, advances and re-places each star, and
// projects each star onto the screen through a pipelined divider.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Direction  Contents
//  -------   ---------          ---------  --------
//  command   start / busy       in         op, star_index, rand_a*, rand_b*
//  result    done (strobe)      out        star_id, plotted, pixel_x/y,
//                                          pixel_address, respawned
//  config    cfg_write          in         cfg_index, cfg_data
//
// One word is taken per clock cycle while busy is low. Every command word
// yields exactly one result word, which passes stages 1 to 3, the
// one-bit-per-stage restoring divider and the output register. Busy is
// raised while an advance word addresses a star whose update has not yet
// been written back to the table (it sits in one of stages 1 to 3), so
// such a word waits until that write-back has landed.
// Reset clears the pipeline valid bits and restores the register defaults;
// the star table itself is undefined until written. The receiver cannot
// stall, so the pipeline never holds.
//
module starfield_point_projector_core #(
    parameter int unsigned TABLE_DEPTH = spp_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned SCREEN_W    = spp_pkg::SCREEN_W_DEF,
    parameter int unsigned SCREEN_H    = spp_pkg::SCREEN_H_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          op,
    input  logic [spp_pkg::ID_W-1:0]      star_index,
    input  logic [spp_pkg::RAND_W-1:0]    rand_ax,
    input  logic [spp_pkg::RAND_W-1:0]    rand_ay,
    input  logic [spp_pkg::RAND_W-1:0]    rand_az,
    input  logic [spp_pkg::RAND_W-1:0]    rand_bx,
    input  logic [spp_pkg::RAND_W-1:0]    rand_by,
    input  logic [spp_pkg::RAND_W-1:0]    rand_bz,
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [spp_pkg::CFG_W-1:0]     cfg_data,
    output logic                          done,
    output logic [spp_pkg::ID_W-1:0]      star_id,
    output logic                          plotted,
    output logic [spp_pkg::PIX_W-1:0]     pixel_x,
    output logic [spp_pkg::PIX_W-1:0]     pixel_y,
    output logic [spp_pkg::ADDR_W-1:0]    pixel_address,
    output logic [1:0]                    respawned
);

    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned XW = $clog2(SCREEN_W + 1);
    localparam int unsigned YW = $clog2(SCREEN_H + 1);
    localparam int unsigned AW = (XW > YW) ? XW : YW;
    // Numerators are half * (pos + z): 25-bit sum times an AW+1-bit constant.
    localparam int unsigned NW = spp_pkg::POS_W + 2 + AW;
    // Divider remainder: the numerator is below 2^AW times the depth.
    localparam int unsigned RW = spp_pkg::POS_W + AW;
    localparam int unsigned PW = 2 * AW + 1;

    localparam logic signed [AW:0] HW_S = (AW+1)'(SCREEN_W / 2);
    localparam logic signed [AW:0] HH_S = (AW+1)'(SCREEN_H / 2);
    localparam logic signed [AW:0] W_S  = (AW+1)'(SCREEN_W);
    localparam logic signed [AW:0] H_S  = (AW+1)'(SCREEN_H);
    localparam logic [AW-1:0]      W_U  = AW'(SCREEN_W);

    // The star index wraps modulo the table depth. A short restoring chain
    // of compare-and-subtract steps on the ten-bit index does this.
    function automatic logic [IW-1:0] wrap_index(input logic [spp_pkg::ID_W-1:0] v);
        logic [spp_pkg::ID_W-1:0] r;
        r = v;
        for (int k = spp_pkg::ID_W - 1; k >= 0; k--)
        begin
            if ((longint'(TABLE_DEPTH) << k) < (longint'(1) << spp_pkg::ID_W))
            begin
                if (longint'(r) >= (longint'(TABLE_DEPTH) << k))
                begin
                    r = r - spp_pkg::ID_W'(longint'(TABLE_DEPTH) << k);
                end
            end
        end
        return IW'(r);
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [spp_pkg::SPREAD_W-1:0] spread_reg;
    logic [spp_pkg::SPEED_W-1:0]  speed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spread_reg <= spp_pkg::SPREAD_RST;
            speed_reg  <= spp_pkg::SPEED_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                spp_pkg::REG_SPREAD: spread_reg <= cfg_data[spp_pkg::SPREAD_W-1:0];
                spp_pkg::REG_SPEED:  speed_reg  <= cfg_data[spp_pkg::SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: accept, table read, placement products for both sets
    // ------------------------------------------------------------------
    logic            accept;
    logic [IW-1:0]   idx_in;
    logic            hazard;

    logic            s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic            s1_op_reg, s2_op_reg, s3_op_reg;
    logic [spp_pkg::ID_W-1:0] s1_id_reg, s2_id_reg, s3_id_reg;
    logic [IW-1:0]   s1_idx_reg, s2_idx_reg, s3_idx_reg;
    spp_pkg::star_t  s1_pa_reg, s1_pb_reg, s2_pb_reg, s3_pb_reg;
    spp_pkg::star_t  s1_rd_reg;
    spp_pkg::star_t  s2_post_reg, s3_post_reg;
    logic            s2_resp0_reg, s3_resp0_reg;
    logic signed [NW-1:0] s3_numx_reg, s3_numy_reg, s3_wz_reg, s3_hz_reg;

    spp_pkg::star_t  star_mem [TABLE_DEPTH];
    spp_pkg::star_t  s3_final;

    assign idx_in = wrap_index(star_index);

    // An advance word must see the write-back of every earlier word for
    // the same star; writes land at the end of stage 3.
    assign hazard = (op == spp_pkg::OP_ADVANCE) &&
                    ((s1_valid_reg && (s1_idx_reg == idx_in)) ||
                     (s2_valid_reg && (s2_idx_reg == idx_in)) ||
                     (s3_valid_reg && (s3_idx_reg == idx_in)));
    assign busy   = hazard;
    assign accept = start && !hazard;

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            star_mem[s3_idx_reg] <= s3_final;
        end
        if (accept)
        begin
            s1_rd_reg <= star_mem[idx_in];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg  <= op;
        s1_id_reg  <= star_index;
        s1_idx_reg <= idx_in;
        s1_pa_reg  <= spp_pkg::place(rand_ax, rand_ay, rand_az, spread_reg);
        s1_pb_reg  <= spp_pkg::place(rand_bx, rand_by, rand_bz, spread_reg);
    end

    // ------------------------------------------------------------------
    // Stage 1: lower the depth, re-place from set A on a place word or when it runs out
    // ------------------------------------------------------------------
    logic signed [spp_pkg::POS_W+1:0] zsub;
    logic                             renew;
    spp_pkg::star_t                   post_next;

    always_comb
    begin
        zsub  = (spp_pkg::POS_W+2)'(s1_rd_reg.z) -
                signed'({6'b0, speed_reg});
        renew = (s1_op_reg == spp_pkg::OP_PLACE) || (zsub <= 0);
        if (renew)
        begin
            post_next = s1_pa_reg;
        end
        else
        begin
            post_next.x = s1_rd_reg.x;
            post_next.y = s1_rd_reg.y;
            post_next.z = zsub[spp_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        s2_op_reg    <= s1_op_reg;
        s2_id_reg    <= s1_id_reg;
        s2_idx_reg   <= s1_idx_reg;
        s2_pb_reg    <= s1_pb_reg;
        s2_post_reg  <= post_next;
        s2_resp0_reg <= renew;
    end

    // ------------------------------------------------------------------
    // Stage 2: numerators half * (pos + z) and the screen bounds times z
    // ------------------------------------------------------------------
    logic signed [spp_pkg::POS_W:0] sx, sy;
    logic signed [NW-1:0]           numx_next, numy_next, wz_next, hz_next;

    always_comb
    begin
        sx        = (spp_pkg::POS_W+1)'(s2_post_reg.x) + (spp_pkg::POS_W+1)'(s2_post_reg.z);
        sy        = (spp_pkg::POS_W+1)'(s2_post_reg.y) + (spp_pkg::POS_W+1)'(s2_post_reg.z);
        numx_next = NW'(HW_S) * NW'(sx);
        numy_next = NW'(HH_S) * NW'(sy);
        wz_next   = NW'(W_S) * NW'(s2_post_reg.z);
        hz_next   = NW'(H_S) * NW'(s2_post_reg.z);
    end

    always_ff @(posedge clk)
    begin
        s3_op_reg    <= s2_op_reg;
        s3_id_reg    <= s2_id_reg;
        s3_idx_reg   <= s2_idx_reg;
        s3_pb_reg    <= s2_pb_reg;
        s3_post_reg  <= s2_post_reg;
        s3_resp0_reg <= s2_resp0_reg;
        s3_numx_reg  <= numx_next;
        s3_numy_reg  <= numy_next;
        s3_wz_reg    <= wz_next;
        s3_hz_reg    <= hz_next;
    end

    // ------------------------------------------------------------------
    // Stage 3: on-screen test without dividing, write-back
    // With z > 0, trunc(num / z) lies in [0, W) exactly when -z < num < W*z.
    // ------------------------------------------------------------------
    logic signed [NW-1:0] negz;
    logic                 shown;
    spp_pkg::meta_t       meta_next;
    logic [RW-1:0]        rx_in, ry_in;

    always_comb
    begin
        negz  = -NW'(s3_post_reg.z);
        shown = (s3_op_reg == spp_pkg::OP_ADVANCE) && (s3_post_reg.z > 0) &&
                (s3_numx_reg > negz) && (s3_numx_reg < s3_wz_reg) &&
                (s3_numy_reg > negz) && (s3_numy_reg < s3_hz_reg);
        if ((s3_op_reg == spp_pkg::OP_PLACE) || shown)
        begin
            s3_final = s3_post_reg;
        end
        else
        begin
            s3_final = s3_pb_reg;
        end
        meta_next.id    = s3_id_reg;
        meta_next.shown = shown;
        if (s3_op_reg == spp_pkg::OP_PLACE)
        begin
            meta_next.resp = 2'b01;
        end
        else
        begin
            meta_next.resp = {!shown, s3_resp0_reg};
        end
        // A negative numerator that is still on screen truncates to column 0.
        rx_in = (s3_numx_reg > 0) ? s3_numx_reg[RW-1:0] : '0;
        ry_in = (s3_numy_reg > 0) ? s3_numy_reg[RW-1:0] : '0;
    end

    // ------------------------------------------------------------------
    // Restoring divider, one quotient bit per stage for both axes
    // ------------------------------------------------------------------
    logic                 dv_valid_reg [AW+1];
    spp_pkg::meta_t       dv_meta_reg  [AW+1];
    logic [AW-1:0]        dv_qx_reg    [AW+1];
    logic [AW-1:0]        dv_qy_reg    [AW+1];
    logic [RW-1:0]        dv_rx_reg    [AW];
    logic [RW-1:0]        dv_ry_reg    [AW];
    logic [spp_pkg::POS_W-1:0] dv_dz_reg [AW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else
        begin
            dv_valid_reg[0] <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dv_meta_reg[0] <= meta_next;
        dv_qx_reg[0]   <= '0;
        dv_qy_reg[0]   <= '0;
        dv_rx_reg[0]   <= rx_in;
        dv_ry_reg[0]   <= ry_in;
        dv_dz_reg[0]   <= s3_post_reg.z[spp_pkg::POS_W-1:0];
    end

    for (genvar k = 0; k < AW; k++)
    begin : g_div
        localparam int unsigned B = AW - 1 - k;

        logic [RW-1:0] dsh;
        logic [RW-1:0] rx_next, ry_next;
        logic [AW-1:0] qx_next, qy_next;

        always_comb
        begin
            dsh     = RW'(dv_dz_reg[k]) << B;
            rx_next = dv_rx_reg[k];
            ry_next = dv_ry_reg[k];
            qx_next = dv_qx_reg[k];
            qy_next = dv_qy_reg[k];
            if (dv_rx_reg[k] >= dsh)
            begin
                rx_next    = dv_rx_reg[k] - dsh;
                qx_next[B] = 1'b1;
            end
            if (dv_ry_reg[k] >= dsh)
            begin
                ry_next    = dv_ry_reg[k] - dsh;
                qy_next[B] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            dv_meta_reg[k+1] <= dv_meta_reg[k];
            dv_qx_reg[k+1]   <= qx_next;
            dv_qy_reg[k+1]   <= qy_next;
        end

        if (k < AW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                dv_rx_reg[k+1] <= rx_next;
                dv_ry_reg[k+1] <= ry_next;
                dv_dz_reg[k+1] <= dv_dz_reg[k];
            end
        end
        else
        begin : g_last
            // The final remainders are of no further use.
            logic unused_rem;
            assign unused_rem = ^{rx_next, ry_next};
        end
    end

    // ------------------------------------------------------------------
    // Address stage and output register
    // ------------------------------------------------------------------
    logic [PW-1:0]                  addr_full;
    logic [PW+spp_pkg::ADDR_W-1:0]  addr_ext;
    logic [AW+spp_pkg::PIX_W-1:0]   px_ext, py_ext;
    spp_pkg::meta_t                 fin_meta;

    logic                           done_reg;
    logic [spp_pkg::ID_W-1:0]       star_id_reg;
    logic                           plotted_reg;
    logic [spp_pkg::PIX_W-1:0]      pixel_x_reg, pixel_y_reg;
    logic [spp_pkg::ADDR_W-1:0]     pixel_address_reg;
    logic [1:0]                     respawned_reg;

    always_comb
    begin
        fin_meta  = dv_meta_reg[AW];
        addr_full = PW'(dv_qy_reg[AW]) * PW'(W_U) + PW'(dv_qx_reg[AW]);
        addr_ext  = (PW+spp_pkg::ADDR_W)'(addr_full);
        px_ext    = (AW+spp_pkg::PIX_W)'(dv_qx_reg[AW]);
        py_ext    = (AW+spp_pkg::PIX_W)'(dv_qy_reg[AW]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid_reg[AW];
        end
    end

    always_ff @(posedge clk)
    begin
        star_id_reg   <= fin_meta.id;
        plotted_reg   <= fin_meta.shown;
        respawned_reg <= fin_meta.resp;
        if (fin_meta.shown)
        begin
            pixel_x_reg       <= px_ext[spp_pkg::PIX_W-1:0];
            pixel_y_reg       <= py_ext[spp_pkg::PIX_W-1:0];
            pixel_address_reg <= addr_ext[spp_pkg::ADDR_W-1:0];
        end
        else
        begin
            pixel_x_reg       <= '0;
            pixel_y_reg       <= '0;
            pixel_address_reg <= '0;
        end
    end

    assign done          = done_reg;
    assign star_id       = star_id_reg;
    assign plotted       = plotted_reg;
    assign pixel_x       = pixel_x_reg;
    assign pixel_y       = pixel_y_reg;
    assign pixel_address = pixel_address_reg;
    assign respawned     = respawned_reg;

endmodule

// File: rtl/core/spp_checker.sv
// ----------------------------------------------------------------------------
// Starfield projector port checker
// Watches the core's ports and checks result timing and result contents.
// ----------------------------------------------------------------------------
module spp_checker #(
    parameter int unsigned SCREEN_W = spp_pkg::SCREEN_W_DEF,
    parameter int unsigned SCREEN_H = spp_pkg::SCREEN_H_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic                          plotted,
    input logic [spp_pkg::PIX_W-1:0]     pixel_x,
    input logic [spp_pkg::PIX_W-1:0]     pixel_y,
    input logic [spp_pkg::ADDR_W-1:0]    pixel_address,
    input logic [1:0]                    respawned
);

    localparam int unsigned XW  = $clog2(SCREEN_W + 1);
    localparam int unsigned YW  = $clog2(SCREEN_H + 1);
    localparam int unsigned AW  = (XW > YW) ? XW : YW;
    localparam int unsigned LAT = AW + 5;

    // Every word taken gives exactly one result strobe.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n, LAT) |-> (done == $past(start && !busy, LAT)))
        else $error("result strobe does not follow the accepted word");

    // A plotted star was never re-placed from set B.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && plotted) |-> (respawned[1] == 1'b0))
        else $error("plotted star marked as re-placed from set B");

    // Nothing plotted means the pixel fields are clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !plotted) |->
            ((pixel_x == '0) && (pixel_y == '0) && (pixel_address == '0)))
        else $error("pixel fields set on a result that plots nothing");

endmodule

bind starfield_point_projector_core spp_checker #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
) u_spp_checker (.*);
